/* hw/rtl/swhtb_pkg.sv */
// Package for the switch hash table builder.
// Sizes, stream layout, state codes and ctrl/dp command and status structs.
// No dependencies.
package swhtb_pkg;

    localparam int MAX_CASES  = 255;
    localparam int MAX_SLOTS  = 256;
    localparam int CASE_AW    = $clog2(MAX_CASES);
    localparam int SLOT_AW    = $clog2(MAX_SLOTS);
    localparam int SH_W       = $clog2(SLOT_AW + 1);
    localparam int VAL_W      = 32;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 72;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_SIZE    = 12'b0000_0000_0010,
        ST_PSTART  = 12'b0000_0000_0100,
        ST_FETCH   = 12'b0000_0000_1000,
        ST_HASH    = 12'b0000_0001_0000,
        ST_PROBE   = 12'b0000_0010_0000,
        ST_PEND    = 12'b0000_0100_0000,
        ST_REBUILD = 12'b0000_1000_0000,
        ST_FINISH  = 12'b0001_0000_0000,
        ST_RD_SLOT = 12'b0010_0000_0000,
        ST_RD_CASE = 12'b0100_0000_0000,
        ST_RD_OUT  = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_accept;
        logic size_init;
        logic pass_start;
        logic hash;
        logic probe;
        logic pass_end;
        logic rebuild;
        logic finish;
        logic rd_slot;
        logic rd_case;
        logic rd_out;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic probe_hit;
        logic last_item;
        logic perfect;
        logic k_last;
    } dp_sts_t;

endpackage

/* hw/rtl/swhtb_ctrl.sv */
// Controller state machine for the switch hash table builder.
// Depends on swhtb_pkg; drives swhtb_dp through dp_cmd_t.
module swhtb_ctrl
    import swhtb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    input  logic    s_tuser,
    input  logic    s_tlast,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   rebuild_reg, rebuild_next;

    assign s_tready = (state_reg == ST_IDLE) && !sts.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rebuild_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rebuild_reg <= rebuild_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        rebuild_next = rebuild_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    if (s_tuser == REQ_LOAD)
                    begin
                        cmd.load = 1'b1;
                        if (s_tlast)
                            state_next = ST_SIZE;
                    end
                    else
                    begin
                        cmd.rd_accept = 1'b1;
                        state_next    = ST_RD_SLOT;
                    end
                end
            end
            ST_SIZE:
            begin
                cmd.size_init = 1'b1;
                rebuild_next  = 1'b0;
                state_next    = ST_PSTART;
            end
            ST_PSTART:
            begin
                cmd.pass_start = 1'b1;
                state_next     = ST_FETCH;
            end
            ST_FETCH:
                state_next = ST_HASH;
            ST_HASH:
            begin
                cmd.hash   = 1'b1;
                state_next = ST_PROBE;
            end
            ST_PROBE:
            begin
                cmd.probe = 1'b1;
                if (!sts.probe_hit)
                    state_next = sts.last_item ? ST_PEND : ST_FETCH;
            end
            ST_PEND:
            begin
                cmd.pass_end = 1'b1;
                if (rebuild_reg || sts.perfect)
                    state_next = ST_FINISH;
                else if (sts.k_last)
                    state_next = ST_REBUILD;
                else
                    state_next = ST_PSTART;
            end
            ST_REBUILD:
            begin
                cmd.rebuild  = 1'b1;
                rebuild_next = 1'b1;
                state_next   = ST_PSTART;
            end
            ST_FINISH:
            begin
                cmd.finish   = 1'b1;
                rebuild_next = 1'b0;
                state_next   = ST_IDLE;
            end
            ST_RD_SLOT:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = ST_RD_CASE;
            end
            ST_RD_CASE:
            begin
                cmd.rd_case = 1'b1;
                state_next  = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                cmd.rd_out = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* hw/rtl/swhtb_dp.sv */
// Datapath for the switch hash table builder: case store, slot table,
// hash and probe unit, best-multiplier tracking and output register.
// Depends on swhtb_pkg; commanded by swhtb_ctrl.
module swhtb_dp
    import swhtb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    logic [VAL_W-1:0]   case_mem [MAX_CASES];
    logic [CASE_AW-1:0] slot_mem [MAX_SLOTS];

    logic [VAL_W-1:0]     case_value;
    logic [SLOT_AW-1:0]   slot_index;

    logic                 set_open_reg;
    logic                 built_reg;
    logic                 ovf_reg;
    logic [CASE_AW-1:0]   count_reg;
    logic [VAL_W-1:0]     base_reg;
    logic [SH_W-1:0]      sh_reg;
    logic [SLOT_AW-1:0]   k_reg;
    logic [SLOT_AW-1:0]   bk_reg;
    logic [CASE_AW:0]     best_reg;
    logic [CASE_AW-1:0]   coll_reg;
    logic [CASE_AW-1:0]   i_reg;
    logic [SLOT_AW-1:0]   z_reg;
    logic                 first_reg;
    logic [MAX_SLOTS-1:0] valid_reg;
    logic [SLOT_AW-1:0]   idx_reg;
    logic                 hit_reg;
    logic [VAL_W-1:0]     case_rd_reg;
    logic [CASE_AW-1:0]   slot_rd_reg;
    logic                 out_valid_reg;
    logic                 out_user_reg;
    logic [M_DATA_W-1:0]  out_data_reg;

    logic [CASE_AW-1:0]   eff_count;
    logic [CASE_AW-1:0]   case_ra;
    logic [SH_W-1:0]      sh_new;
    logic [SLOT_AW:0]     size;
    logic [SLOT_AW-1:0]   mask;
    logic [VAL_W-1:0]     v;
    logic [VAL_W-1:0]     v_sh;
    logic [2*SLOT_AW-1:0] prod;
    logic [SLOT_AW-1:0]   z_new;
    logic                 rd_hit;

    assign case_value = s_tdata[VAL_W-1:0];
    assign slot_index = s_tdata[VAL_W +: SLOT_AW];

    assign eff_count = set_open_reg ? count_reg : '0;
    assign case_ra   = cmd.rd_case ? (slot_rd_reg - CASE_AW'(1)) : i_reg;

    always_comb
    begin
        sh_new = SH_W'(1);
        for (int b = 0; b < CASE_AW; b++)
        begin
            if (count_reg[b])
                sh_new = SH_W'(b + 1);
        end
    end

    assign size  = (SLOT_AW+1)'(1) << sh_reg;
    assign mask  = SLOT_AW'(size - (SLOT_AW+1)'(1));
    assign v     = case_rd_reg - base_reg;
    assign v_sh  = v >> sh_reg;
    assign prod  = v_sh[SLOT_AW-1:0] * k_reg;
    assign z_new = (prod[SLOT_AW-1:0] + v[SLOT_AW-1:0]) & mask;

    assign rd_hit = built_reg && ({1'b0, idx_reg} < size) && valid_reg[idx_reg];

    assign sts.out_busy  = out_valid_reg;
    assign sts.probe_hit = valid_reg[z_reg];
    assign sts.last_item = ({1'b0, i_reg} + (CASE_AW+1)'(1)) == {1'b0, count_reg};
    assign sts.perfect   = (coll_reg == '0);
    assign sts.k_last    = ({1'b0, k_reg} == (size - (SLOT_AW+1)'(1)));

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_user_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && (eff_count < CASE_AW'(MAX_CASES)))
            case_mem[eff_count] <= case_value;
        case_rd_reg <= case_mem[case_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe && !valid_reg[z_reg])
            slot_mem[z_reg] <= i_reg + CASE_AW'(1);
        slot_rd_reg <= slot_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_accept)
            idx_reg <= slot_index;
        if (cmd.rd_slot)
            hit_reg <= rd_hit;
        if (cmd.load && (eff_count == '0))
            base_reg <= case_value;
        if (cmd.hash)
            z_reg <= z_new;
        else if (cmd.probe && valid_reg[z_reg])
            z_reg <= (z_reg + SLOT_AW'(1)) & mask;
        if (cmd.hash)
            first_reg <= 1'b1;
        else if (cmd.probe)
            first_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_open_reg  <= 1'b0;
            built_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            count_reg     <= '0;
            sh_reg        <= '0;
            k_reg         <= '0;
            bk_reg        <= '0;
            best_reg      <= '1;
            coll_reg      <= '0;
            i_reg         <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_user_reg  <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            if (cmd.load)
            begin
                set_open_reg <= 1'b1;
                built_reg    <= 1'b0;
                if (eff_count < CASE_AW'(MAX_CASES))
                begin
                    count_reg <= eff_count + CASE_AW'(1);
                    ovf_reg   <= set_open_reg ? ovf_reg : 1'b0;
                end
                else
                begin
                    count_reg <= eff_count;
                    ovf_reg   <= 1'b1;
                end
            end
            if (cmd.size_init)
            begin
                sh_reg   <= sh_new;
                k_reg    <= SLOT_AW'(1);
                bk_reg   <= SLOT_AW'(1);
                best_reg <= '1;
            end
            if (cmd.pass_start)
            begin
                valid_reg <= '0;
                coll_reg  <= '0;
                i_reg     <= '0;
            end
            if (cmd.probe)
            begin
                if (valid_reg[z_reg])
                begin
                    if (first_reg)
                        coll_reg <= coll_reg + CASE_AW'(1);
                end
                else
                begin
                    valid_reg[z_reg] <= 1'b1;
                    i_reg            <= i_reg + CASE_AW'(1);
                end
            end
            if (cmd.pass_end)
            begin
                if ({1'b0, coll_reg} < best_reg)
                begin
                    best_reg <= {1'b0, coll_reg};
                    bk_reg   <= k_reg;
                end
                k_reg <= k_reg + SLOT_AW'(1);
            end
            if (cmd.rebuild)
                k_reg <= bk_reg;
            if (cmd.finish)
            begin
                set_open_reg  <= 1'b0;
                built_reg     <= 1'b1;
                out_valid_reg <= 1'b1;
                out_user_reg  <= 1'b1;
                out_data_reg  <= M_DATA_W'({ovf_reg, best_reg[CASE_AW-1:0], size, bk_reg});
            end
            if (cmd.rd_out)
            begin
                out_valid_reg <= 1'b1;
                out_user_reg  <= 1'b0;
                if (hit_reg)
                    out_data_reg <= M_DATA_W'({v, slot_rd_reg, 1'b0, 26'd0});
                else
                    out_data_reg <= M_DATA_W'({1'b1, 26'd0});
            end
        end
    end

endmodule

/* hw/rtl/switch_hash_table_builder.sv */
// Top level of the switch hash table builder.
// Instantiates swhtb_ctrl and swhtb_dp; depends on swhtb_pkg.
//
// channel  dir  tdata (low bit up)                         tuser       tlast
// s_*      in   case_value[31:0], slot_index[39:32]        req_type    last_case
// m_*      out  hash_multiplier[7:0], table_size[16:8],    is_summary  -
//               collision_count[24:17], overflow[25], slot_empty[26],
//               slot_case[34:27], slot_offset[66:35], zero[71:67]
//
// A non-last load leaves the builder idle; a read runs RD_SLOT, RD_CASE and RD_OUT.
// The last load runs the multiplier search: each pass clears the slots, fetches
// each case, hashes it, probes to a free slot; up to size-1 passes and one rebuild.
// s_tready is low during the search, during a read and while a result waits.
// rst_n clears control state; stored values and slots are unknown until written.
module switch_hash_table_builder
    import swhtb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // case_value, slot_index
    input  logic                s_tuser,  // req_type
    input  logic                s_tlast,  // last_case
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // multiplier, size, collisions, overflow,
                                          // empty, case, offset
    output logic                m_tuser   // is_summary
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    swhtb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swhtb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/swhtb_checker.sv */
// Port-level checker for the switch hash table builder, bound to the top level.
// Depends on swhtb_pkg.
module swhtb_checker
    import swhtb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid)
        else $error("input accepted while a result waits");

    a_size_pow2: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> $onehot(m_tdata[16:8]))
        else $error("table size is not a power of two");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser && m_tdata[26] |-> m_tdata[66:27] == '0)
        else $error("empty slot carries data");

endmodule

bind switch_hash_table_builder swhtb_checker u_swhtb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/switch_hash_table_builder_tb.sv */
// Testbench for switch_hash_table_builder: random and directed load/read streams,
// results checked against a behavioral hash table builder kept in a scoreboard class.
// Depends on swhtb_pkg and the switch_hash_table_builder RTL.
`timescale 1ns / 100ps

module switch_hash_table_builder_tb;
    import swhtb_pkg::*;

    typedef struct {
        logic        is_summary;
        logic [7:0]  multiplier;
        logic [8:0]  size;
        logic [7:0]  collisions;
        logic        overflow;
        logic        empty;
        logic [7:0]  case_num;
        logic [31:0] offset;
    } table_result_t;

    class hash_table_scoreboard;
        logic [31:0]   case_vals [MAX_CASES];
        int            n_cases;
        logic [31:0]   base;
        int            slot_owner [MAX_SLOTS];
        int            built_size;
        bit            set_open;
        bit            ovf_seen;
        table_result_t pending [$];
        int            errors;
        int            n_summaries;
        int            n_reads;
        int            n_overflows;

        function void clear();
            n_cases = 0;
            base = '0;
            built_size = 0;
            set_open = 0;
            ovf_seen = 0;
            foreach (slot_owner[i])
                slot_owner[i] = 0;
        endfunction

        function int place_cases(int k, int size, int sh);
            int coll;
            int z;
            int steps;
            logic [31:0] v;
            logic [31:0] h;
            coll = 0;
            foreach (slot_owner[i])
                slot_owner[i] = 0;
            for (int i = 0; i < n_cases; i++)
            begin
                v = case_vals[i] - base;
                h = ((v >> sh) * k) + v;
                z = h & (size - 1);
                if (slot_owner[z] != 0)
                begin
                    coll++;
                    steps = 0;
                    while (slot_owner[z] != 0 && steps < size)
                    begin
                        z = (z + 1) & (size - 1);
                        steps++;
                    end
                end
                if (slot_owner[z] == 0)
                    slot_owner[z] = i + 1;
            end
            return coll;
        endfunction

        function void search_multiplier(output int best_k, output int best_c);
            int size;
            int sh;
            int c;
            size = 1;
            sh = 0;
            best_c = -1;
            best_k = 1;
            while (size <= n_cases && size < MAX_SLOTS)
            begin
                size *= 2;
                sh++;
            end
            for (int k = 1; k < size; k++)
            begin
                c = place_cases(k, size, sh);
                if (best_c < 0 || c < best_c)
                begin
                    best_c = c;
                    best_k = k;
                end
                if (c == 0)
                    break;
            end
            if (best_c < 0)
                best_c = place_cases(best_k, size, sh);
            else if (best_c != 0)
                void'(place_cases(best_k, size, sh));
            built_size = size;
        endfunction

        function void note_input(logic req, logic [31:0] value, logic last, logic [7:0] idx);
            table_result_t r;
            int bk;
            int bc;
            int c;
            r = '{default: '0};
            if (req == REQ_LOAD)
            begin
                if (!set_open)
                begin
                    n_cases = 0;
                    ovf_seen = 0;
                    built_size = 0;
                    set_open = 1;
                end
                if (n_cases < MAX_CASES)
                begin
                    if (n_cases == 0)
                        base = value;
                    case_vals[n_cases] = value;
                    n_cases++;
                end
                else
                    ovf_seen = 1;
                if (!last)
                    return;
                search_multiplier(bk, bc);
                set_open = 0;
                r.is_summary = 1;
                r.multiplier = bk[7:0];
                r.size = built_size[8:0];
                r.collisions = (bc > 255) ? 8'hFF : bc[7:0];
                r.overflow = ovf_seen;
                n_summaries++;
                if (ovf_seen)
                    n_overflows++;
            end
            else
            begin
                n_reads++;
                c = (built_size != 0 && idx < built_size) ? slot_owner[idx] : 0;
                if (c != 0 && c <= n_cases)
                begin
                    r.case_num = c[7:0];
                    r.offset = case_vals[c - 1] - base;
                end
                else
                    r.empty = 1;
            end
            pending.push_back(r);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                     want);
        endtask

        task check_result(table_result_t got);
            table_result_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with no pending expectation", $realtime);
                return;
            end
            want = pending.pop_front();
            if (got.is_summary !== want.is_summary)
                report("is_summary", 32'(got.is_summary), 32'(want.is_summary));
            if (got.multiplier !== want.multiplier)
                report("hash_multiplier", 32'(got.multiplier), 32'(want.multiplier));
            if (got.size !== want.size)
                report("table_size", 32'(got.size), 32'(want.size));
            if (got.collisions !== want.collisions)
                report("collision_count", 32'(got.collisions), 32'(want.collisions));
            if (got.overflow !== want.overflow)
                report("overflow", 32'(got.overflow), 32'(want.overflow));
            if (got.empty !== want.empty)
                report("slot_empty", 32'(got.empty), 32'(want.empty));
            if (got.case_num !== want.case_num)
                report("slot_case", 32'(got.case_num), 32'(want.case_num));
            if (got.offset !== want.offset)
                report("slot_offset", got.offset, want.offset);
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;

    hash_table_scoreboard sb;
    int  items_sent;
    bit  calm;
    bit  hold_req;
    bit  out_fire;
    logic [M_DATA_W-1:0] out_data;
    logic                out_user;

    switch_hash_table_builder DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
        clk = 0;
    always #5 clk = ~clk;

    initial
    begin
        #200_000_000;
        $display("Timeout with %0d results outstanding", sb.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

    // sample away from the active edge, act on the next one
    always @(negedge clk)
    begin
        out_fire <= m_tvalid && m_tready;
        out_data <= m_tdata;
        out_user <= m_tuser;
    end

    always @(posedge clk)
    begin
        table_result_t got;
        if (rst_n && out_fire)
        begin
            got.is_summary = out_user;
            got.multiplier = out_data[7:0];
            got.size = out_data[16:8];
            got.collisions = out_data[24:17];
            got.overflow = out_data[25];
            got.empty = out_data[26];
            got.case_num = out_data[34:27];
            got.offset = out_data[66:35];
            sb.check_result(got);
        end
    end

    initial
    begin
        m_tready <= 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 0;
                repeat (400) @(posedge clk);
                hold_req = 0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task send(logic req, logic [31:0] value, logic last, logic [7:0] idx);
        bit acc;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tlast <= last;
        s_tdata <= {idx, value};
        do
        begin
            @(negedge clk);
            acc = s_tready;
            @(posedge clk);
        end
        while (!acc);
        sb.note_input(req, value, last, idx);
        items_sent++;
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task load_set(int n, int step_mode);
        logic [31:0] v;
        v = $urandom;
        for (int i = 0; i < n; i++)
        begin
            send(REQ_LOAD, v, i == n - 1, 8'($urandom));
            case (step_mode)
                0: v = v + $urandom_range(1, 3);
                1: v = v + ($urandom & 32'h0000_0FFF) + 1;
                default: v = v + ($urandom & 32'h00FF_FFFF) + 1;
            endcase
        end
    endtask

    task read_slots(int n, int size);
        for (int i = 0; i < n; i++)
            if ($urandom_range(0, 7) == 0)
                send(REQ_READ, $urandom, 1'($urandom), 8'($urandom));
            else
                send(REQ_READ, $urandom, 1'($urandom), 8'($urandom_range(0, size - 1)));
    endtask

    initial
    begin
        int n;
        sb = new();
        sb.clear();
        sb.errors = 0;
        items_sent = 0;
        calm = 0;
        hold_req = 0;
        rst_n <= 0;
        s_tvalid <= 0;
        s_tuser <= 0;
        s_tlast <= 0;
        s_tdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send(REQ_READ, 32'h0, 1'b0, 8'd0);
        send(REQ_READ, 32'hFFFF_FFFF, 1'b1, 8'd255);
        send(REQ_LOAD, 32'hFFFF_FFFF, 1'b1, 8'hFF);
        send(REQ_READ, 32'h0, 1'b0, 8'd0);
        send(REQ_READ, 32'h0, 1'b0, 8'd1);
        send(REQ_LOAD, 32'hFFFF_FFF0, 1'b0, 8'h00);
        send(REQ_READ, 32'h0, 1'b0, 8'd0);
        send(REQ_LOAD, 32'h0000_0005, 1'b1, 8'h00);
        for (int i = 0; i < 4; i++)
            send(REQ_READ, 32'h0, 1'b0, 8'(i));
        send(REQ_LOAD, 32'h0000_0000, 1'b0, 8'h00);
        send(REQ_LOAD, 32'h0000_0100, 1'b0, 8'h00);
        send(REQ_LOAD, 32'h0000_0100, 1'b0, 8'h00);
        send(REQ_LOAD, 32'h0000_0010, 1'b1, 8'h00);
        for (int i = 0; i < 8; i++)
            send(REQ_READ, 32'h0, 1'b0, 8'(i));
        drain();

        hold_req = 1;
        read_slots(30, 8);
        drain();

        for (int i = 0; i < 300; i++)
            send(REQ_LOAD, 32'(i), i == 299, 8'h00);
        read_slots(20, 256);
        send(REQ_READ, 32'h0, 1'b0, 8'd255);
        drain();

        while (items_sent < 1900)
        begin
            if (items_sent > 1650)
                calm = 1;
            case ($urandom_range(0, 9))
                0: read_slots($urandom_range(1, 4), 256);
                1:
                begin
                    n = $urandom_range(20, 40);
                    load_set(n, $urandom_range(0, 2));
                    read_slots(12, 64);
                end
                default:
                begin
                    n = $urandom_range(1, 12);
                    load_set(n, $urandom_range(0, 2));
                    read_slots($urandom_range(n, 2 * n + 2), 16);
                end
            endcase
        end

        s_tvalid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("Sent %0d transactions: %0d table builds (%0d with overflow), %0d slot reads.",
                 items_sent, sb.n_summaries, sb.n_overflows, sb.n_reads);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
